// ===== hdl/xtea_pkg.sv =====
`default_nettype none

package xtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ROUND_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned KEY_WORDS = 4;

  localparam logic [WORD_W-1:0]  DELTA      = 32'h9E37_79B9;
  localparam logic [ROUND_W-1:0] MAX_ROUNDS = 7'd64;

  localparam logic [WORD_W-1:0]  KEY0_RST   = 32'h0000_FDA5;
  localparam logic [WORD_W-1:0]  KEY1_RST   = 32'h0000_D54E;
  localparam logic [WORD_W-1:0]  KEY2_RST   = 32'h0000_FC00;
  localparam logic [WORD_W-1:0]  KEY3_RST   = 32'h0000_B55A;
  localparam logic [ROUND_W-1:0] ROUNDS_RST = 7'd32;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // take a new block, seed the sum
    logic step;      // run one Feistel cycle on the working state
    logic capture;   // write the output register
    logic use_step;  // capture the round result rather than the held state
  } cmd_t;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/xtea_if.sv =====
`default_nettype none

interface xtea_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [xtea_pkg::WORD_W-1:0] block_low;
  logic [xtea_pkg::WORD_W-1:0] block_high;

  modport source (output valid, mode, block_low, block_high, input ready);
  modport sink   (input valid, mode, block_low, block_high, output ready);
endinterface

interface xtea_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [xtea_pkg::WORD_W-1:0] result_low;
  logic [xtea_pkg::WORD_W-1:0] result_high;

  modport source (output valid, result_low, result_high, input ready);
  modport sink   (input valid, result_low, result_high, output ready);
endinterface

interface xtea_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [xtea_pkg::CFG_IDX_W-1:0] index;
  logic [xtea_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/xtea_cfg_regs.sv =====
`default_nettype none

module xtea_cfg_regs (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           wr_en_i,
  input  wire [xtea_pkg::CFG_IDX_W-1:0] wr_idx_i,
  input  wire [xtea_pkg::WORD_W-1:0]    wr_data_i,
  output xtea_pkg::key_t                key_o,
  output logic [xtea_pkg::ROUND_W-1:0]  rounds_o
);
  import xtea_pkg::*;

  key_t               key_q, key_d;
  logic [ROUND_W-1:0] rounds_q, rounds_d;
  logic [ROUND_W-1:0] wr_rounds;

  // Saturate the round count on write so the core only ever sees 0..64
  assign wr_rounds = (wr_data_i[ROUND_W-1:0] > MAX_ROUNDS) ? MAX_ROUNDS
                                                           : wr_data_i[ROUND_W-1:0];

  always_comb begin
    key_d    = key_q;
    rounds_d = rounds_q;
    if (wr_en_i) begin
      unique case (wr_idx_i) inside
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_d[wr_idx_i[1:0]] = wr_data_i;
        REG_ROUNDS:                             rounds_d = wr_rounds;
        default:                                ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= {KEY3_RST, KEY2_RST, KEY1_RST, KEY0_RST};
      rounds_q <= ROUNDS_RST;
    end else begin
      key_q    <= key_d;
      rounds_q <= rounds_d;
    end
  end

  assign key_o    = key_q;
  assign rounds_o = rounds_q;

endmodule

`default_nettype wire

// ===== hdl/xtea_ctrl.sv =====
`default_nettype none

module xtea_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          req_valid_i,
  output logic                         req_ready_o,
  output logic                         rsp_valid_o,
  input  wire                          rsp_ready_i,
  input  wire [xtea_pkg::ROUND_W-1:0]  rounds_i,
  output xtea_pkg::cmd_t               cmd_o
);
  import xtea_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [ROUND_W-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               accept;
  logic               out_free;
  logic               last;

  assign accept   = req_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || rsp_ready_i;
  assign last     = (cnt_q <= ROUND_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RUN;
      ST_RUN:  if (last && out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and counter
  always_comb begin
    cmd_o       = '0;
    cnt_d       = cnt_q;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = rounds_i;
        end
      end
      ST_RUN: begin
        if (!last) begin
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q - ROUND_W'(1);
        end else if (out_free) begin
          cmd_o.capture  = 1'b1;
          cmd_o.use_step = (cnt_q != '0);
        end else if (cnt_q != '0) begin
          // Output still occupied: finish the last cycle and hold
          cmd_o.step = 1'b1;
          cnt_d      = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture)    out_valid_d = 1'b1;
    else if (rsp_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/xtea_dpath.sv =====
`default_nettype none

module xtea_dpath (
  input  wire                          clk_i,
  input  wire xtea_pkg::cmd_t          cmd_i,
  input  wire xtea_pkg::key_t          key_i,
  input  wire [xtea_pkg::ROUND_W-1:0]  rounds_i,
  input  wire                          mode_i,
  input  wire [xtea_pkg::WORD_W-1:0]   block_low_i,
  input  wire [xtea_pkg::WORD_W-1:0]   block_high_i,
  output logic [xtea_pkg::WORD_W-1:0]  result_low_o,
  output logic [xtea_pkg::WORD_W-1:0]  result_high_o
);
  import xtea_pkg::*;

  logic [WORD_W-1:0] a_q, a_d, b_q, b_d, s_q, s_d;
  logic              mode_q, mode_d;
  logic [WORD_W-1:0] res_lo_q, res_lo_d, res_hi_q, res_hi_d;
  logic [WORD_W-1:0] a_nxt, b_nxt, s_nxt;
  logic [WORD_W-1:0] enc_a, enc_s, enc_b;
  logic [WORD_W-1:0] dec_b, dec_s, dec_a;
  logic [WORD_W-1:0] dec_seed;

  assign dec_seed = WORD_W'(DELTA * rounds_i);

  // Encipher cycle
  assign enc_a = a_q + (mix(b_q) ^ (s_q + key_i[s_q[1:0]]));
  assign enc_s = s_q + DELTA;
  assign enc_b = b_q + (mix(enc_a) ^ (enc_s + key_i[enc_s[12:11]]));

  // Decipher cycle
  assign dec_b = b_q - (mix(a_q) ^ (s_q + key_i[s_q[12:11]]));
  assign dec_s = s_q - DELTA;
  assign dec_a = a_q - (mix(dec_b) ^ (dec_s + key_i[dec_s[1:0]]));

  assign a_nxt = mode_q ? dec_a : enc_a;
  assign b_nxt = mode_q ? dec_b : enc_b;
  assign s_nxt = mode_q ? dec_s : enc_s;

  always_comb begin
    a_d      = a_q;
    b_d      = b_q;
    s_d      = s_q;
    mode_d   = mode_q;
    res_lo_d = res_lo_q;
    res_hi_d = res_hi_q;
    if (cmd_i.load) begin
      a_d    = block_low_i;
      b_d    = block_high_i;
      mode_d = mode_i;
      s_d    = mode_i ? dec_seed : '0;
    end else if (cmd_i.step) begin
      a_d = a_nxt;
      b_d = b_nxt;
      s_d = s_nxt;
    end
    if (cmd_i.capture) begin
      res_lo_d = cmd_i.use_step ? a_nxt : a_q;
      res_hi_d = cmd_i.use_step ? b_nxt : b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    s_q      <= s_d;
    mode_q   <= mode_d;
    res_lo_q <= res_lo_d;
    res_hi_q <= res_hi_d;
  end

  assign result_low_o  = res_lo_q;
  assign result_high_o = res_hi_q;

endmodule

`default_nettype wire

// ===== hdl/xtea_block_cipher.sv =====
`default_nettype none

// XTEA block cipher, one 64-bit block per request. A request carries the two
// 32-bit halves of the block and a mode bit (0 encipher, 1 decipher); the
// response carries the processed halves. The 128-bit key (four words,
// configuration indices 0..3) and the round count (index 4, low 7 bits only;
// values above 64 saturate to 64, zero passes the block through) sit in
// configuration registers, always ready, and should only be written while no
// request is in flight. Indices beyond 4 are ignored. Round logic with one
// encipher and one decipher path, reused for every round, runs one full
// Feistel cycle per clock: the core accepts a block and seeds the sum, then
// runs the rounds, the last of which writes the output register. A new
// request is taken as soon as the core is free, even while the previous
// response waits in the output register; the core holds its finished result
// only when that register is still occupied.
module xtea_block_cipher (
  input  wire         clk_i,
  input  wire         rst_ni,
  xtea_req_if.sink    req_i,
  xtea_rsp_if.source  rsp_o,
  xtea_cfg_if.sink    cfg_i
);
  import xtea_pkg::*;

  key_t               key;
  logic [ROUND_W-1:0] rounds;
  cmd_t               cmd;

  // Configuration registers never stall
  assign cfg_i.ready = 1'b1;

  xtea_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .key_o     (key),
    .rounds_o  (rounds)
  );

  // Sequencer: accept, count rounds, hand off to the output register
  xtea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rounds_i    (rounds),
    .cmd_o       (cmd)
  );

  // Round unit, working state and output register
  xtea_dpath u_dpath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .key_i         (key),
    .rounds_i      (rounds),
    .mode_i        (req_i.mode),
    .block_low_i   (req_i.block_low),
    .block_high_i  (req_i.block_high),
    .result_low_o  (rsp_o.result_low),
    .result_high_o (rsp_o.result_high)
  );

endmodule

`default_nettype wire

// ===== hdl/xtea_checker.sv =====
`default_nettype none

module xtea_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        req_valid_i,
  input wire                        req_ready_i,
  input wire                        rsp_valid_i,
  input wire                        rsp_ready_i,
  input wire [xtea_pkg::WORD_W-1:0] result_low_i,
  input wire [xtea_pkg::WORD_W-1:0] result_high_i,
  input wire                        cfg_ready_i
);

  // A stalled response holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(result_low_i) && $stable(result_high_i))
    else $error("stalled response changed");

  // The core is not ready again in the cycle after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while core busy");

  // A new response only comes out of a running core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("response appeared from an idle core");

  // Configuration writes never stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port stalled");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .result_low_i  (rsp_o.result_low),
  .result_high_i (rsp_o.result_high),
  .cfg_ready_i   (cfg_i.ready)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import xtea_pkg::*;

  // Cipher constants and register reset values, kept apart from the package
  localparam logic [WORD_W-1:0]  XTEA_DELTA    = 32'h9E37_79B9;
  localparam int                 ROUND_CAP     = 64;
  localparam logic [ROUND_W-1:0] ROUND_DEFAULT = 7'd32;
  localparam logic [WORD_W-1:0]  KEY_RESET [KEY_WORDS] =
    '{32'h0000_FDA5, 32'h0000_D54E, 32'h0000_FC00, 32'h0000_B55A};

  // Indices past the round count register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(REG_ROUNDS + 1);

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Idle margin after the last response before config writes
  localparam int DRAIN_CYCLES      = 80;
  localparam int ITEMS_PER_SETTING = 180;
  localparam int HOLD_OFF_CYCLES   = 400;
  localparam int BURST_ITEMS       = 20;

  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
  } cipher_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
  } cipher_blk_t;

  logic clk = 1'b0;
  logic rst_n;

  xtea_req_if req ();
  xtea_rsp_if rsp ();
  xtea_cfg_if cfg ();

  xtea_block_cipher DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers
  logic [WORD_W-1:0]  key_model [KEY_WORDS];
  logic [ROUND_W-1:0] round_model;

  // Expected processed blocks, oldest first
  cipher_blk_t expected_blocks [$];

  int unsigned mismatch_count = 0;
  int unsigned req_idle_pct   = 0;
  int unsigned rsp_stall_pct  = 0;
  int unsigned hold_off_left  = 0;

  function automatic logic [WORD_W-1:0] shift_mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  // Run the block through the Feistel cycles under the current key and round count
  function automatic cipher_blk_t xtea_transform(input cipher_req_t r);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] s;
    int                n;
    cipher_blk_t       res;
    a = r.low;
    b = r.high;
    // counts above the cap saturate; zero passes the block through
    n = (round_model > ROUND_CAP) ? ROUND_CAP : int'(round_model);
    if (r.mode == MODE_ENC) begin
      s = '0;
      for (int i = 0; i < n; i++) begin
        a = a + (shift_mix(b) ^ (s + key_model[s[1:0]]));
        s = s + XTEA_DELTA;
        b = b + (shift_mix(a) ^ (s + key_model[s[12:11]]));
      end
    end else begin
      // start from delta times rounds, wrapped to 32 bits
      s = XTEA_DELTA * n;
      for (int i = 0; i < n; i++) begin
        b = b - (shift_mix(a) ^ (s + key_model[s[12:11]]));
        s = s - XTEA_DELTA;
        a = a - (shift_mix(b) ^ (s + key_model[s[1:0]]));
      end
    end
    res.low  = a;
    res.high = b;
    return res;
  endfunction

  // Bias toward all-zero and all-one words so the extremes show up often
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // A quarter of the requests decipher a freshly enciphered block (round trip)
  function automatic cipher_req_t random_request();
    cipher_req_t r;
    cipher_blk_t ct;
    r.mode = 1'($urandom_range(1));
    r.low  = rand_word();
    r.high = rand_word();
    if ($urandom_range(3) == 0) begin
      ct = xtea_transform('{MODE_ENC, r.low, r.high});
      r  = '{MODE_DEC, ct.low, ct.high};
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one request, with a random idle gap in front; keep valid high afterwards
  // so back-to-back requests never drop it within the same step
  task automatic send_block(input cipher_req_t r);
    if ($urandom_range(99) < req_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
    end
    req.valid      <= 1'b1;
    req.mode       <= r.mode;
    req.block_low  <= r.low;
    req.block_high <= r.high;
    do @(posedge clk); while (!req.ready);
    expected_blocks.push_back(xtea_transform(r));
  endtask

  // Drop valid, wait for every outstanding response, then idle for extra cycles
  task automatic drain_core(input int extra);
    req.valid <= 1'b0;
    do @(posedge clk); while (expected_blocks.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx < KEY_WORDS) begin
      key_model[idx] = value;
    end else if (idx == REG_ROUNDS) begin
      round_model = value[ROUND_W-1:0];
    end
    @(posedge clk);
  endtask

  task automatic reprogram_random();
    logic [WORD_W-1:0] rc;
    drain_core(DRAIN_CYCLES);
    for (int k = 0; k < KEY_WORDS; k++) write_reg(CFG_IDX_W'(REG_KEY0 + k), rand_word());
    case ($urandom_range(9))
      0: rc = 0;
      1: rc = $urandom_range(2**ROUND_W - 1, ROUND_CAP + 1);
      2: rc = ROUND_CAP;
      default: rc = $urandom_range(ROUND_CAP, 1);
    endcase
    // junk above the round count field must be masked off
    write_reg(REG_ROUNDS, rc | ($urandom << ROUND_W));
    if ($urandom_range(2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_UNUSED_FIRST)), $urandom);
    end
  endtask

  // Reset key and round count: zero and all-one blocks in both directions, then a round trip
  task automatic test_default_key();
    cipher_blk_t ct;
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    send_block('{MODE_ENC, '0, '0});
    send_block('{MODE_DEC, '0, '0});
    send_block('{MODE_ENC, '1, '1});
    send_block('{MODE_DEC, '1, '1});
    ct = xtea_transform('{MODE_ENC, 32'h0123_4567, 32'h89AB_CDEF});
    send_block('{MODE_DEC, ct.low, ct.high});
  endtask

  // One round, the cap, zero (pass through) and counts above the cap (saturate)
  task automatic test_round_limits();
    logic [WORD_W-1:0] counts [5] =
      '{32'h0000_0001, 32'h0000_0040, 32'hFFFF_FF80, 32'h0000_0041, 32'hFFFF_FFFF};
    cipher_req_t r;
    cipher_blk_t ct;
    foreach (counts[k]) begin
      drain_core(DRAIN_CYCLES);
      write_reg(REG_ROUNDS, counts[k]);
      r  = '{MODE_ENC, rand_word(), rand_word()};
      ct = xtea_transform(r);
      send_block(r);
      send_block('{MODE_DEC, ct.low, ct.high});
    end
  endtask

  // All-zero and all-one keys, then writes to unused indices that must change nothing
  task automatic test_key_extremes();
    drain_core(DRAIN_CYCLES);
    for (int k = 0; k < KEY_WORDS; k++) write_reg(CFG_IDX_W'(REG_KEY0 + k), '0);
    write_reg(REG_ROUNDS, ROUND_DEFAULT);
    send_block('{MODE_ENC, '1, '1});
    drain_core(DRAIN_CYCLES);
    for (int k = 0; k < KEY_WORDS; k++) write_reg(CFG_IDX_W'(REG_KEY0 + k), '1);
    send_block('{MODE_ENC, '0, '0});
    send_block('{MODE_DEC, '0, '0});
    drain_core(DRAIN_CYCLES);
    for (int k = REG_UNUSED_FIRST; k < 2**CFG_IDX_W; k++) write_reg(CFG_IDX_W'(k), '1);
    send_block('{MODE_ENC, rand_word(), rand_word()});
  endtask

  // Random requests under random settings, through each idling pattern
  task automatic test_random_traffic();
    int unsigned idle_pct  [4] = '{0, 67, 0, 29};
    int unsigned stall_pct [4] = '{0, 0, 67, 29};
    foreach (idle_pct[p]) begin
      repeat (2) begin
        reprogram_random();
        req_idle_pct  = idle_pct[p];
        rsp_stall_pct = stall_pct[p];
        repeat (ITEMS_PER_SETTING) send_block(random_request());
      end
    end
  endtask

  // Hold the response side off while requests keep coming so the core backs up,
  // then pause the requests until every response is back; repeat with random response stalls
  task automatic test_backpressure();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (BURST_ITEMS) send_block(random_request());
    drain_core(0);
    rsp_stall_pct = 29;
    repeat (BURST_ITEMS) send_block(random_request());
    drain_core(0);
  endtask

  // Response side: check each accepted response, then pick ready for the next edge
  always @(posedge clk) begin
    cipher_blk_t want;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (expected_blocks.size() == 0) begin
        report_error($sformatf("response %h_%h with no request outstanding",
                               rsp.result_high, rsp.result_low));
      end else begin
        want = expected_blocks.pop_front();
        if (rsp.result_low !== want.low) begin
          report_error($sformatf("result_low: expected %h, got %h", want.low, rsp.result_low));
        end
        if (rsp.result_high !== want.high) begin
          report_error($sformatf("result_high: expected %h, got %h",
                                 want.high, rsp.result_high));
        end
      end
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  initial begin
    rst_n          = 1'b0;
    req.valid      = 1'b0;
    req.mode       = MODE_ENC;
    req.block_low  = '0;
    req.block_high = '0;
    cfg.valid      = 1'b0;
    cfg.index      = REG_KEY0;
    cfg.data       = '0;
    rsp.ready      = 1'b0;
    key_model      = KEY_RESET;
    round_model    = ROUND_DEFAULT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_default_key();
    test_round_limits();
    test_key_extremes();
    test_random_traffic();
    test_backpressure();

    drain_core(DRAIN_CYCLES);
    if (expected_blocks.size() != 0) begin
      report_error($sformatf("%0d responses never arrived", expected_blocks.size()));
    end
    if (mismatch_count == 0) begin
      $display("** xtea_block_cipher: PASSED **");
    end else begin
      $display("** xtea_block_cipher: FAILED **");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is well under a tenth of this
  initial begin
    #20_000_000;
    $display("%0t ns: ERROR timeout", $time);
    $display("** xtea_block_cipher: FAILED **");
    $finish;
  end

endmodule
